[design/integer_field_to_ascii_formatter_assert.svh]
// Assertion macros shared by the formatter modules.
// Each macro samples on clk and is disabled while rst_n is low; no other dependencies.
`ifndef INTEGER_FIELD_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_FIELD_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define IFA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IFA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ifa_pkg.sv]
// Package for the integer field to ASCII formatter: codes, characters, state and control types.
// Used by every other file but the assertion macro header; depends on nothing.
`timescale 1ns / 1ps

package ifa_pkg;

    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned HEX_MAX    = 11;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);

    typedef enum logic [1:0] {
        FUNC_SDEC = 2'd0,
        FUNC_UDEC = 2'd1,
        FUNC_HEX  = 2'd2,
        FUNC_CHAR = 2'd3
    } func_t;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [3:0] NIB_MASK = 4'hF;
    localparam logic [3:0] RADIX    = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CONV  = 2'd1,
        ST_SETUP = 2'd2,
        ST_EMIT  = 2'd3
    } state_t;

    typedef struct packed {
        logic idle;
        logic conv_step;
        logic setup;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic conv_done;
        logic out_free;
        logic emit_last;
    } ctrl_sts_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < RADIX)
        begin
            ch = CH_ZERO + {4'h0, nib};
        end
        else
        begin
            ch = CH_UPPER_A + {4'h0, nib - RADIX};
        end
        return ch;
    endfunction

endpackage

[design/ifa_ifs.sv]
// Valid/ready channel interfaces for the formatter's request and character streams.
// Payload widths come from ifa_pkg.
`timescale 1ns / 1ps

interface ifa_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      func;
    logic [1:0]                      size;
    logic [3:0]                      width;
    logic                            zero_fill;
    logic [ifa_pkg::VALUE_W-1:0]     value;

    modport source (output valid, output func, output size, output width,
                    output zero_fill, output value, input ready);
    modport sink   (input valid, input func, input size, input width,
                    input zero_fill, input value, output ready);
endinterface

interface ifa_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);
endinterface

[design/ifa_ctrl.sv]
// Controller state machine of the formatter: sequences load, conversion, setup and emission.
// Depends on ifa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "integer_field_to_ascii_formatter_assert.svh"

module ifa_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ifa_pkg::ctrl_sts_t   sts,
    output ifa_pkg::ctrl_cmd_t   cmd
);

    ifa_pkg::state_t state_reg;
    ifa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ifa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ifa_pkg::ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = ifa_pkg::ST_CONV;
                end
            end
            ifa_pkg::ST_CONV:
            begin
                if (sts.conv_done)
                begin
                    state_next = ifa_pkg::ST_SETUP;
                end
            end
            ifa_pkg::ST_SETUP:
            begin
                state_next = ifa_pkg::ST_EMIT;
            end
            ifa_pkg::ST_EMIT:
            begin
                if (sts.out_free && sts.emit_last)
                begin
                    state_next = ifa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ifa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ifa_pkg::ST_IDLE:  cmd.idle = 1'b1;
            ifa_pkg::ST_CONV:  cmd.conv_step = 1'b1;
            ifa_pkg::ST_SETUP: cmd.setup = 1'b1;
            ifa_pkg::ST_EMIT:  cmd.emit = sts.out_free;
            default:           cmd = '0;
        endcase
    end

    `IFA_ASSERT_IMP(a_emit_needs_slot, cmd.emit, sts.out_free, "emit issued while output slot busy")
    `IFA_ASSERT_NXT(a_conv_to_setup, state_reg == ifa_pkg::ST_CONV && sts.conv_done, state_reg == ifa_pkg::ST_SETUP, "conversion did not end in setup")
    `IFA_ASSERT_NXT(a_last_to_idle, cmd.emit && sts.emit_last, state_reg == ifa_pkg::ST_IDLE, "final character did not return to idle")

endmodule

[design/ifa_dp.sv]
// Datapath of the formatter: operand registers, shift-add-3 decimal converter and character unit.
// Depends on ifa_pkg, the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "integer_field_to_ascii_formatter_assert.svh"

module ifa_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ifa_pkg::ctrl_cmd_t   cmd,
    output ifa_pkg::ctrl_sts_t   sts,
    ifa_req_if.sink              din,
    ifa_chr_if.source            dout
);

    localparam int unsigned VW = ifa_pkg::VALUE_W;
    localparam int unsigned DW = ifa_pkg::DIGIT_W;
    localparam int unsigned ND = ifa_pkg::DEC_DIGITS;
    localparam int unsigned PW = ifa_pkg::POS_W;

    ifa_pkg::func_t                   func_reg;
    logic [1:0]                       size_reg;
    logic [3:0]                       width_reg;
    logic                             zero_fill_reg;
    logic [VW-1:0]                    raw_reg;
    logic                             neg_reg;
    logic                             neg_next;
    logic [VW-1:0]                    shift_reg;
    logic [DW-1:0]                    bcd_reg [ND];
    logic [DW-1:0]                    bcd_next [ND];
    logic [ifa_pkg::BIT_CNT_W-1:0]    bit_cnt_reg;
    logic [PW-1:0]                    pos_reg;
    logic [PW-1:0]                    pos_next;
    logic                             lead_reg;
    logic                             lead_next;
    logic                             out_valid_reg;
    logic [7:0]                       char_reg;
    logic [7:0]                       char_next;
    logic                             last_reg;

    logic                             load;
    logic [VW-1:0]                    raw_in;
    logic [VW-1:0]                    neg_val;
    logic [VW-1:0]                    mag_in;
    logic                             sign_in;
    logic                             neg_in;
    logic [PW-1:0]                    dec_cnt;
    logic [PW-1:0]                    hex_cnt;
    logic                             nz_above;
    logic [DW-1:0]                    cur_digit;
    logic [3:0]                       cur_nib;
    logic                             emit_last;

    function automatic logic [VW-1:0] size_mask(input logic [1:0] sz, input logic [VW-1:0] v);
        logic [VW-1:0] r;
        case (sz)
            ifa_pkg::SIZE_BYTE: r = {{(VW-8){1'b0}}, v[7:0]};
            ifa_pkg::SIZE_WORD: r = {{(VW-16){1'b0}}, v[15:0]};
            default:            r = v;
        endcase
        return r;
    endfunction

    assign load      = din.valid && cmd.idle;
    assign din.ready = cmd.idle;

    always_comb
    begin
        raw_in  = size_mask(din.size, din.value);
        neg_val = size_mask(din.size, (~raw_in) + {{(VW-1){1'b0}}, 1'b1});
        case (din.size)
            ifa_pkg::SIZE_BYTE: sign_in = din.value[7];
            ifa_pkg::SIZE_WORD: sign_in = din.value[15];
            default:            sign_in = din.value[VW-1];
        endcase
        neg_in = (din.func == ifa_pkg::FUNC_SDEC) && sign_in;
        mag_in = neg_in ? neg_val : raw_in;
    end

    always_comb
    begin
        logic [DW-1:0] adj;
        for (int i = 0; i < ND; i++)
        begin
            adj = (bcd_reg[i] >= DW'(5)) ? bcd_reg[i] + DW'(3) : bcd_reg[i];
            bcd_next[i] = adj;
        end
        for (int i = ND - 1; i > 0; i--)
        begin
            bcd_next[i] = {bcd_next[i][DW-2:0], bcd_next[i-1][DW-1]};
        end
        bcd_next[0] = {bcd_next[0][DW-2:0], shift_reg[VW-1]};
    end

    always_comb
    begin
        logic [PW-1:0] top_idx;
        top_idx = '0;
        for (int i = 0; i < ND; i++)
        begin
            if (bcd_reg[i] != '0)
            begin
                top_idx = PW'(i);
            end
        end
        if (width_reg == '0)
        begin
            dec_cnt = top_idx + PW'(1);
        end
        else if (width_reg > PW'(ND))
        begin
            dec_cnt = PW'(ND);
        end
        else
        begin
            dec_cnt = width_reg;
        end
        nz_above = 1'b0;
        for (int i = 0; i < ND; i++)
        begin
            if (PW'(i) >= dec_cnt && bcd_reg[i] != '0)
            begin
                nz_above = 1'b1;
            end
        end
        if (width_reg == '0)
        begin
            case (size_reg)
                ifa_pkg::SIZE_BYTE: hex_cnt = PW'(2);
                ifa_pkg::SIZE_WORD: hex_cnt = PW'(4);
                default:            hex_cnt = PW'(8);
            endcase
        end
        else if (width_reg > PW'(ifa_pkg::HEX_MAX))
        begin
            hex_cnt = PW'(ifa_pkg::HEX_MAX);
        end
        else
        begin
            hex_cnt = width_reg;
        end
    end

    always_comb
    begin
        cur_digit = (pos_reg < PW'(ND)) ? bcd_reg[pos_reg] : '0;
        cur_nib   = (pos_reg >= PW'(8)) ? 4'h0
                  : (raw_reg[{pos_reg[2:0], 2'b00} +: 4] & ifa_pkg::NIB_MASK);
        emit_last = !neg_reg && (pos_reg == '0);
        pos_next  = pos_reg;
        lead_next = lead_reg;
        neg_next  = neg_reg;
        char_next = ifa_pkg::CH_SPACE;
        if (cmd.setup)
        begin
            lead_next = zero_fill_reg || nz_above;
            case (func_reg)
                ifa_pkg::FUNC_HEX:  pos_next = hex_cnt - PW'(1);
                ifa_pkg::FUNC_CHAR: pos_next = '0;
                default:            pos_next = dec_cnt - PW'(1);
            endcase
        end
        else if (cmd.emit)
        begin
            if (neg_reg)
            begin
                char_next = ifa_pkg::CH_MINUS;
                neg_next  = 1'b0;
            end
            else
            begin
                case (func_reg)
                    ifa_pkg::FUNC_CHAR:
                    begin
                        char_next = raw_reg[7:0];
                    end
                    ifa_pkg::FUNC_HEX:
                    begin
                        char_next = ifa_pkg::hex_char(cur_nib);
                    end
                    default:
                    begin
                        if (!lead_reg && cur_digit == '0 && pos_reg != '0)
                        begin
                            char_next = ifa_pkg::CH_SPACE;
                        end
                        else
                        begin
                            char_next = ifa_pkg::CH_ZERO + {4'h0, cur_digit};
                            lead_next = 1'b1;
                        end
                    end
                endcase
                if (pos_reg != '0)
                begin
                    pos_next = pos_reg - PW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg      <= ifa_pkg::func_t'(din.func);
            size_reg      <= din.size;
            width_reg     <= din.width;
            zero_fill_reg <= din.zero_fill;
            raw_reg       <= raw_in;
            shift_reg     <= mag_in;
            bit_cnt_reg   <= '0;
            for (int i = 0; i < ND; i++)
            begin
                bcd_reg[i] <= '0;
            end
        end
        else if (cmd.conv_step)
        begin
            shift_reg   <= {shift_reg[VW-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + ifa_pkg::BIT_CNT_W'(1);
            bcd_reg     <= bcd_next;
        end
        if (load)
        begin
            neg_reg <= neg_in;
        end
        else
        begin
            neg_reg <= neg_next;
        end
        pos_reg  <= pos_next;
        lead_reg <= lead_next;
        if (cmd.emit)
        begin
            char_reg <= char_next;
            last_reg <= emit_last;
        end
    end

    assign sts.in_valid  = din.valid;
    assign sts.conv_done = (bit_cnt_reg == '1);
    assign sts.out_free  = !out_valid_reg || dout.ready;
    assign sts.emit_last = emit_last;

    assign dout.valid    = out_valid_reg;
    assign dout.char_out = char_reg;
    assign dout.last     = last_reg;

    `IFA_ASSERT_NXT(a_setup_pos_range, cmd.setup,
        pos_reg <= PW'(ifa_pkg::HEX_MAX - 1), "field position out of range after setup")
    `IFA_ASSERT_NXT(a_last_flag, cmd.emit && emit_last,
        out_valid_reg && last_reg, "final character not marked last")
    `IFA_ASSERT_NXT(a_load_clears_count, load,
        bit_cnt_reg == '0, "conversion count not cleared on load")

endmodule

[design/integer_field_to_ascii_formatter.sv]
// Top level of the integer field to ASCII formatter: joins controller and datapath.
// Depends on ifa_pkg, the channel interfaces, ifa_ctrl and ifa_dp.
//
//   channel  role    payload                                  beat
//   din      sink    func, size, width, zero_fill, value      one conversion request
//   dout     source  char_out, last                           one ASCII character
//
// A request is taken only in the idle state. It is loaded, passes through the shift-add-3
// decimal converter one step per value bit, and then through setup before its first character.
// Its 1 to 11 characters then leave back to back while dout takes them.
// Reset is asynchronous and active low and clears the controller and the output valid flag.
// A stalled dout holds the current character; emission waits for the output slot to free.
`timescale 1ns / 1ps

module integer_field_to_ascii_formatter
(
    input  logic        clk,
    input  logic        rst_n,
    ifa_req_if.sink     din,
    ifa_chr_if.source   dout
);

    ifa_pkg::ctrl_cmd_t cmd;
    ifa_pkg::ctrl_sts_t sts;

    ifa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ifa_dp u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .din   (din),
        .dout  (dout)
    );

endmodule

[sim/tb_top.sv]
// Self-checking bench for integer_field_to_ascii_formatter: a predictor builds each field's text.
// The checker compares every output beat with it. Depends on ifa_pkg, ifa_ifs.sv and the design.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] SIZE_LONG  = 2'd2;
    localparam logic [1:0] SIZE_THREE = 2'd3;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned PRINT_CAP    = 40;

    logic clk;
    logic rst_n;

    ifa_req_if req_ch ();
    ifa_chr_if chr_ch ();

    integer_field_to_ascii_formatter dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (req_ch),
        .dout  (chr_ch)
    );

    logic [7:0]  exp_char_q[$];
    logic        exp_last_q[$];

    int unsigned mismatches;
    int unsigned n_requests;
    int unsigned n_chars;
    int unsigned n_func[4];
    int unsigned quiet_cycles;
    bit          no_idle;
    bit          hold_out_req;
    int unsigned hold_count;
    logic [7:0]  want_char;
    logic        want_last;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < PRINT_CAP)
        begin
            $display("%0t ns: mismatch on %s: got 0x%02h, expected 0x%02h",
                     $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic logic [31:0] power_of_ten(input int unsigned k);
        logic [31:0] p;
        p = 32'd1;
        for (int unsigned i = 0; i < k; i++)
        begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    // Builds the expected characters of one field and queues them.
    task automatic format_field(input ifa_pkg::func_t f, input logic [1:0] sz,
                                input logic [3:0] w, input logic zf, input logic [31:0] v);
        logic [7:0]  chars[12];
        int unsigned n;
        int unsigned bits;
        int unsigned cnt;
        int unsigned sh;
        logic [31:0] raw;
        logic [31:0] mag;
        logic [31:0] q;
        logic [63:0] full;
        logic [3:0]  nib;
        logic        lead;
        n = 0;
        bits = (sz == ifa_pkg::SIZE_BYTE) ? 8 : (sz == ifa_pkg::SIZE_WORD) ? 16 : 32;
        raw = (bits == 32) ? v : (v & ((32'd1 << bits) - 32'd1));
        case (f)
            ifa_pkg::FUNC_CHAR:
            begin
                chars[n] = raw[7:0];
                n++;
            end
            ifa_pkg::FUNC_HEX:
            begin
                cnt = (w != 4'd0) ? int'(w) : bits / 4;
                if (cnt > ifa_pkg::HEX_MAX)
                begin
                    cnt = ifa_pkg::HEX_MAX;
                end
                for (int unsigned i = 0; i < cnt; i++)
                begin
                    sh = (cnt - 1 - i) * 4;
                    nib = (sh >= 32) ? 4'd0 : 4'((raw >> sh) & 32'h0000_000F);
                    chars[n] = (nib < 4'd10) ? (ifa_pkg::CH_ZERO + {4'd0, nib})
                                             : (ifa_pkg::CH_UPPER_A + {4'd0, nib} - 8'd10);
                    n++;
                end
            end
            default:
            begin
                mag = raw;
                lead = zf;
                if (f == ifa_pkg::FUNC_SDEC && raw[bits-1])
                begin
                    chars[n] = ifa_pkg::CH_MINUS;
                    n++;
                    full = (64'd1 << bits) - {32'd0, raw};
                    mag = full[31:0];
                end
                cnt = (w > 4'd10) ? ifa_pkg::DEC_DIGITS : int'(w);
                if (cnt == 0)
                begin
                    cnt = 1;
                    while (cnt < ifa_pkg::DEC_DIGITS && (mag / power_of_ten(cnt)) != 32'd0)
                    begin
                        cnt++;
                    end
                end
                for (int unsigned k = cnt; k > 0; k--)
                begin
                    q = mag / power_of_ten(k - 1);
                    if (q == 32'd0 && !lead && k != 1)
                    begin
                        chars[n] = ifa_pkg::CH_SPACE;
                    end
                    else
                    begin
                        chars[n] = ifa_pkg::CH_ZERO + 8'(q % 32'd10);
                        lead = 1'b1;
                    end
                    n++;
                end
            end
        endcase
        for (int unsigned i = 0; i < n; i++)
        begin
            exp_char_q.push_back(chars[i]);
            exp_last_q.push_back(i == n - 1);
        end
    endtask

    // Offers one request beat and waits until the block takes it.
    task automatic send_field(input ifa_pkg::func_t f, input logic [1:0] sz,
                              input logic [3:0] w, input logic zf, input logic [31:0] v);
        int unsigned gap;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= f;
        req_ch.size      <= sz;
        req_ch.width     <= w;
        req_ch.zero_fill <= zf;
        req_ch.value     <= v;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        format_field(f, sz, w, zf, v);
        n_requests++;
        n_func[f]++;
    endtask

    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        while (exp_char_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 99);
            1: v = power_of_ten($urandom_range(1, 9)) - 32'($urandom_range(0, 1));
            2:
            begin
                case ($urandom_range(0, 7))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_007F;
                    2: v = 32'h0000_0080;
                    3: v = 32'h0000_FFFF;
                    4: v = 32'h0000_8000;
                    5: v = 32'h7FFF_FFFF;
                    6: v = 32'h8000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            3: v = {16'($urandom_range(0, 65535)), 16'h0} | 32'($urandom_range(0, 255));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] rand_width();
        return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 10));
    endfunction

    task automatic send_random(input int unsigned count);
        repeat (count)
        begin
            send_field(ifa_pkg::func_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       rand_width(), 1'($urandom_range(0, 1)), rand_value());
        end
    endtask

    task automatic test_directed();
        send_field(ifa_pkg::FUNC_SDEC, ifa_pkg::SIZE_BYTE, 4'd0,  1'b0, 32'h0000_0080);
        send_field(ifa_pkg::FUNC_SDEC, ifa_pkg::SIZE_BYTE, 4'd0,  1'b0, 32'h0000_007F);
        send_field(ifa_pkg::FUNC_SDEC, SIZE_LONG,          4'd0,  1'b0, 32'h8000_0000);
        send_field(ifa_pkg::FUNC_SDEC, SIZE_LONG,          4'd0,  1'b0, 32'hFFFF_FFFF);
        send_field(ifa_pkg::FUNC_UDEC, SIZE_LONG,          4'd0,  1'b0, 32'hFFFF_FFFF);
        send_field(ifa_pkg::FUNC_UDEC, ifa_pkg::SIZE_BYTE, 4'd0,  1'b0, 32'h0000_0000);
        send_field(ifa_pkg::FUNC_UDEC, ifa_pkg::SIZE_WORD, 4'd5,  1'b0, 32'h0000_0000);
        send_field(ifa_pkg::FUNC_UDEC, ifa_pkg::SIZE_WORD, 4'd5,  1'b1, 32'd42);
        send_field(ifa_pkg::FUNC_UDEC, SIZE_LONG,          4'd3,  1'b0, 32'd12345);
        send_field(ifa_pkg::FUNC_UDEC, SIZE_LONG,          4'd3,  1'b0, 32'd1005);
        send_field(ifa_pkg::FUNC_SDEC, ifa_pkg::SIZE_WORD, 4'd10, 1'b0, 32'h0000_8000);
        send_field(ifa_pkg::FUNC_SDEC, SIZE_LONG,          4'd15, 1'b1, 32'h8000_0000);
        send_field(ifa_pkg::FUNC_SDEC, SIZE_THREE,         4'd0,  1'b0, 32'hFFFF_FF85);
        send_field(ifa_pkg::FUNC_SDEC, ifa_pkg::SIZE_BYTE, 4'd0,  1'b0, 32'hFFFF_FF7F);
        send_field(ifa_pkg::FUNC_HEX,  ifa_pkg::SIZE_BYTE, 4'd0,  1'b0, 32'h0000_00A5);
        send_field(ifa_pkg::FUNC_HEX,  ifa_pkg::SIZE_WORD, 4'd0,  1'b0, 32'h0000_BEEF);
        send_field(ifa_pkg::FUNC_HEX,  SIZE_LONG,          4'd0,  1'b0, 32'hDEAD_BEEF);
        send_field(ifa_pkg::FUNC_HEX,  SIZE_LONG,          4'd11, 1'b0, 32'h0123_ABCD);
        send_field(ifa_pkg::FUNC_HEX,  ifa_pkg::SIZE_WORD, 4'd15, 1'b0, 32'hFFFF_FFFF);
        send_field(ifa_pkg::FUNC_HEX,  SIZE_THREE,         4'd1,  1'b1, 32'h0000_0007);
        send_field(ifa_pkg::FUNC_CHAR, SIZE_THREE,         4'd15, 1'b1, 32'hFFFF_FF41);
        send_field(ifa_pkg::FUNC_CHAR, ifa_pkg::SIZE_BYTE, 4'd0,  1'b0, 32'h0000_0000);
        send_field(ifa_pkg::FUNC_CHAR, ifa_pkg::SIZE_WORD, 4'd9,  1'b0, 32'h1234_5620);
        wait_for_drain();
    endtask

    task automatic test_random_traffic();
        send_random(250);
    endtask

    task automatic test_output_backpressure();
        hold_out_req = 1'b1;
        send_random(8);
        wait_for_drain();
    endtask

    task automatic test_sender_pause();
        repeat (3)
        begin
            send_random(10);
            wait_for_drain();
        end
    endtask

    task automatic test_full_rate();
        no_idle = 1'b1;
        send_random(120);
        wait_for_drain();
    endtask

    initial
    begin
        chr_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_out_req)
            begin
                hold_out_req = 1'b0;
                chr_ch.ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_count++;
                end
                chr_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else if (!no_idle && $urandom_range(0, 6) == 0)
            begin
                chr_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                chr_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                chr_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && chr_ch.valid && chr_ch.ready)
        begin
            if (exp_char_q.size() == 0)
            begin
                report_mismatch("character with no request pending", chr_ch.char_out, 8'h00);
            end
            else
            begin
                want_char = exp_char_q.pop_front();
                want_last = exp_last_q.pop_front();
                n_chars++;
                if (chr_ch.char_out !== want_char)
                begin
                    report_mismatch("char_out", chr_ch.char_out, want_char);
                end
                if (chr_ch.last !== want_last)
                begin
                    report_mismatch("last", {7'd0, chr_ch.last}, {7'd0, want_last});
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (chr_ch.valid && chr_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d cycles without a beat", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        mismatches   = 0;
        n_requests   = 0;
        n_chars      = 0;
        n_func       = '{default: 0};
        quiet_cycles = 0;
        no_idle      = 1'b0;
        hold_out_req = 1'b0;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.func      <= ifa_pkg::FUNC_SDEC;
        req_ch.size      <= ifa_pkg::SIZE_BYTE;
        req_ch.width     <= 4'd0;
        req_ch.zero_fill <= 1'b0;
        req_ch.value     <= 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();
        test_full_rate();

        $display("Sent %0d requests (%0d signed, %0d unsigned, %0d hex, %0d char), %0d chars.",
                 n_requests, n_func[0], n_func[1], n_func[2], n_func[3], n_chars);
        $display("Included output hold-off, sender pauses and full-rate traffic; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
